FILE: rtl/crcfr_pkg.sv
// Package for the CRC-checked frame receiver: result item type, header phase
// and verdict codes, and the byte-wide reflected CRC-32 update.
// No dependencies.
package crcfr_pkg;

  localparam logic [31:0] CrcPoly    = 32'hEDB88320;
  localparam logic [31:0] CrcInit    = 32'hFFFFFFFF;
  localparam int unsigned MaskCrcBit = 3;

  localparam logic KindPayload = 1'b0;
  localparam logic KindVerdict = 1'b1;

  typedef enum logic [3:0] {
    PH_MASK    = 4'd0,
    PH_SUM0    = 4'd1,
    PH_SUM1    = 4'd2,
    PH_SUM2    = 4'd3,
    PH_SUM3    = 4'd4,
    PH_SKIP0   = 4'd5,
    PH_SKIP1   = 4'd6,
    PH_SKIP2   = 4'd7,
    PH_SKIP3   = 4'd8,
    PH_TYPE    = 4'd9,
    PH_PAYLOAD = 4'd10
  } crcfr_phase_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_SHORT    = 2'd2
  } crcfr_status_e;

  typedef struct packed {
    logic              kind;
    logic [7:0]        payload_byte;
    logic              end_of_payload;
    logic signed [7:0] frame_type;
    crcfr_status_e     status;
  } crcfr_item_t;

  // Up to two results per input beat; item1 is only used together with item0.
  typedef struct packed {
    logic        push0;
    logic        push1;
    crcfr_item_t item0;
    crcfr_item_t item1;
  } crcfr_push_t;

  // One byte through the reflected CRC-32, all eight bit steps unrolled.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

FILE: rtl/crcfr_parser.sv
// Input beat register, frame header parser, CRC-32 and verdict logic.
// Produces up to two result items per beat for the output queue.
// Depends on crcfr_pkg.
module crcfr_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_data_i,
  input  logic                 accept_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 last_byte_i,
  output logic                 busy_o,
  output crcfr_pkg::crcfr_push_t push_o
);
  import crcfr_pkg::*;

  logic         skip_hdr_q;
  logic         in_valid_q;
  logic [7:0]   in_data_q;
  logic         in_last_q;

  crcfr_phase_e phase_q, phase_d, after_sum;
  logic         has_sum_q, has_sum_d;
  logic [31:0]  rcv_q, rcv_d;
  logic [31:0]  crc_q, crc_d, crc_upd;
  logic [7:0]   type_q, type_d;
  logic         type_seen;
  crcfr_status_e verdict;
  crcfr_item_t  vitem;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_hdr_q <= 1'b0;
      in_valid_q <= 1'b0;
      phase_q    <= PH_MASK;
      has_sum_q  <= 1'b0;
      rcv_q      <= '0;
      crc_q      <= CrcInit;
      type_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        skip_hdr_q <= cfg_data_i;
      end
      in_valid_q <= accept_i;
      phase_q    <= phase_d;
      has_sum_q  <= has_sum_d;
      rcv_q      <= rcv_d;
      crc_q      <= crc_d;
      type_q     <= type_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      in_data_q <= data_byte_i;
      in_last_q <= last_byte_i;
    end
  end

  assign busy_o    = in_valid_q;
  assign crc_upd   = crc_byte(crc_q, in_data_q);
  assign after_sum = skip_hdr_q ? PH_SKIP0 : PH_TYPE;

  always_comb begin
    phase_d   = phase_q;
    has_sum_d = has_sum_q;
    rcv_d     = rcv_q;
    crc_d     = crc_q;
    type_d    = type_q;
    type_seen = 1'b0;
    verdict   = ST_OK;
    vitem     = '0;
    push_o    = '0;

    if (in_valid_q) begin
      unique case (phase_q)
        PH_MASK: begin
          has_sum_d = in_data_q[MaskCrcBit];
          phase_d   = in_data_q[MaskCrcBit] ? PH_SUM0 : after_sum;
        end
        PH_SUM0, PH_SUM1, PH_SUM2: begin
          rcv_d   = {rcv_q[23:0], in_data_q};
          phase_d = crcfr_phase_e'(phase_q + 4'd1);
        end
        PH_SUM3: begin
          rcv_d   = {rcv_q[23:0], in_data_q};
          phase_d = after_sum;
        end
        PH_SKIP0, PH_SKIP1, PH_SKIP2, PH_SKIP3: begin
          crc_d   = crc_upd;
          phase_d = crcfr_phase_e'(phase_q + 4'd1);
        end
        PH_TYPE: begin
          crc_d   = crc_upd;
          type_d  = in_data_q;
          phase_d = PH_PAYLOAD;
        end
        default: begin
          // Payload phase; unused phase codes behave the same way.
          crc_d                       = crc_upd;
          push_o.push0                = 1'b1;
          push_o.item0.kind           = KindPayload;
          push_o.item0.payload_byte   = in_data_q;
          push_o.item0.end_of_payload = in_last_q;
          push_o.item0.frame_type     = type_q;
          push_o.item0.status         = ST_OK;
        end
      endcase

      if (in_last_q) begin
        type_seen = (phase_d == PH_PAYLOAD) || (4'(phase_q) >= 4'(PH_PAYLOAD));
        priority if (!type_seen) begin
          verdict = ST_SHORT;
        end else if (has_sum_d && ((~crc_d) != rcv_d)) begin
          verdict = ST_MISMATCH;
        end else begin
          verdict = ST_OK;
        end
        vitem.kind       = KindVerdict;
        vitem.frame_type = type_d;
        vitem.status     = verdict;
        if (push_o.push0) begin
          push_o.push1 = 1'b1;
          push_o.item1 = vitem;
        end else begin
          push_o.push0 = 1'b1;
          push_o.item0 = vitem;
        end
        // The frame is over: back to the reset state for the next one.
        phase_d   = PH_MASK;
        has_sum_d = 1'b0;
        rcv_d     = '0;
        crc_d     = CrcInit;
        type_d    = '0;
      end
    end
  end

  a_frame_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && in_last_q) |=> (phase_q == PH_MASK && crc_q == CrcInit && type_q == 8'd0))
    else $error("frame state not cleared after final byte");

  a_second_is_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.push1 |-> (push_o.item1.kind == KindVerdict && push_o.item0.kind == KindPayload))
    else $error("two results must be payload then verdict");

  a_verdict_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.push0 && push_o.item0.kind == KindVerdict) |-> (in_last_q && in_valid_q))
    else $error("verdict without final byte");

endmodule

FILE: rtl/crcfr_out_fifo.sv
// Result queue between the parser and the output stream; takes up to two
// items per cycle and hands out one. Depth must be a power of two, at least 4.
// Depends on crcfr_pkg.
module crcfr_out_fifo #(
  parameter int unsigned Depth = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  crcfr_pkg::crcfr_push_t         push_i,
  input  logic                           pop_i,
  output crcfr_pkg::crcfr_item_t         item_o,
  output logic                           valid_o,
  output logic [$clog2(Depth+1)-1:0]     count_o
);
  import crcfr_pkg::*;

  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned CW = $clog2(Depth + 1);

  crcfr_item_t   mem_q [Depth];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_ptr_nx;
  logic [CW-1:0] count_q, count_d;

  assign wr_ptr_nx = wr_ptr_q + AW'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + AW'(push_i.push0) + AW'(push_i.push1);
    rd_ptr_d = rd_ptr_q + AW'(pop_i);
    count_d  = count_q + CW'(push_i.push0) + CW'(push_i.push1) - CW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push0) begin
      mem_q[wr_ptr_q] <= push_i.item0;
    end
    if (push_i.push1) begin
      mem_q[wr_ptr_nx] <= push_i.item1;
    end
  end

  assign item_o  = mem_q[rd_ptr_q];
  assign valid_o = (count_q != '0);
  assign count_o = count_q;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(Depth))
    else $error("result queue overflow");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != CW'(Depth)) |-> (wr_ptr_q - rd_ptr_q == count_q[AW-1:0]))
    else $error("queue pointers disagree with fill count");

endmodule

FILE: rtl/crc_checked_frame_receiver_top.sv
// Top level of the CRC-checked frame receiver: stream ports, config port and
// ready logic around the parser and the result queue.
// Depends on crcfr_pkg, crcfr_parser and crcfr_out_fifo.
//
//  Channel  | Direction | Beat contents
//  ---------+-----------+----------------------------------------------------
//  cfg      | in        | header skip enable (1 bit)
//  s_axis   | in        | tdata: data_byte; tlast: last_byte
//  m_axis   | out       | tdata: payload_byte, frame_type, status; tuser: kind;
//           |           | tlast: end_of_payload
//
// One input byte per cycle while the queue has room; a byte is registered when
// accepted, parsed and CRC-updated in the next cycle and written to the queue at
// the end of that cycle. A payload byte that ends a frame yields two output beats;
// the queue absorbs them. s_axis_tready_o drops when the queue could not take two
// items each for the byte in the input register and for a new one. Reset is
// asynchronous and active low; the config port is always ready.
module crc_checked_frame_receiver_top #(
  parameter int unsigned FifoDepth = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,      // header skip enable
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] data_byte
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,  // [7:0] payload_byte, [15:8] frame_type,
                                       // [17:16] status, [23:18] zero
  output logic        m_axis_tlast_o,
  output logic        m_axis_tuser_o   // kind
);
  import crcfr_pkg::*;

  localparam int unsigned CW = $clog2(FifoDepth + 1);

  crcfr_push_t   push;
  crcfr_item_t   item;
  logic          busy, accept, pop, q_valid;
  logic [CW-1:0] count;
  logic [CW:0]   need;

  // Room for the beat in the input register and for the one just accepted.
  assign need            = {1'b0, count} + (busy ? (CW+1)'(2) : '0);
  assign s_axis_tready_o = (need <= (CW+1)'(FifoDepth - 2));
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;
  assign pop             = q_valid && m_axis_tready_i;

  crcfr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .data_byte_i (s_axis_tdata_i),
    .last_byte_i (s_axis_tlast_i),
    .busy_o      (busy),
    .push_o      (push)
  );

  crcfr_out_fifo #(
    .Depth (FifoDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .item_o  (item),
    .valid_o (q_valid),
    .count_o (count)
  );

  assign m_axis_tvalid_o = q_valid;
  assign m_axis_tdata_o  = {6'd0, item.status, item.frame_type, item.payload_byte};
  assign m_axis_tlast_o  = item.end_of_payload;
  assign m_axis_tuser_o  = item.kind;

endmodule

FILE: tb/crcfr_checker.sv
// Scoreboard for the CRC-checked frame receiver: watches the config, input and
// output channels, predicts the result beats of every accepted byte and compares.
// Depends on crcfr_pkg for the result item type and the phase and verdict codes.
`timescale 1ns / 1ps

module crcfr_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_data_i,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [23:0] m_axis_tdata_i,   // [7:0] payload_byte, [15:8] frame_type,
                                        // [17:16] status, [23:18] zero
  input  logic        m_axis_tlast_i,
  input  logic        m_axis_tuser_i,   // kind
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import crcfr_pkg::*;

  logic         skip_hdr_q;
  crcfr_phase_e hdr_phase_q;
  logic         sum_present_q;
  logic [31:0]  sum_rx_q;
  logic [31:0]  crc_q;
  logic [7:0]   type_q;
  crcfr_item_t  beats_due_q[$];
  int unsigned  fails;

  // Reflected CRC-32, one data bit per step, LSB first.
  function automatic logic [31:0] crc32_step(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      if (c[0] ^ b[k]) c = (c >> 1) ^ CrcPoly;
      else c = c >> 1;
    end
    return c;
  endfunction

  function automatic crcfr_item_t make_item(input logic kind, input logic [7:0] pb,
                                            input logic eop, input logic [7:0] ft,
                                            input crcfr_status_e st);
    crcfr_item_t it;
    it.kind           = kind;
    it.payload_byte   = pb;
    it.end_of_payload = eop;
    it.frame_type     = ft;
    it.status         = st;
    return it;
  endfunction

  task automatic clear_frame();
    hdr_phase_q   = PH_MASK;
    sum_present_q = 1'b0;
    sum_rx_q      = '0;
    crc_q         = CrcInit;
    type_q        = '0;
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic last);
    crcfr_phase_e  ph;
    crcfr_phase_e  after_sum;
    logic          type_seen;
    crcfr_status_e st;
    ph = hdr_phase_q;
    // The mode is taken at the moment the header leaves the mask or checksum field.
    after_sum = skip_hdr_q ? PH_SKIP0 : PH_TYPE;
    if (ph == PH_MASK) begin
      sum_present_q = b[MaskCrcBit];
      hdr_phase_q   = sum_present_q ? PH_SUM0 : after_sum;
    end else if (ph >= PH_SUM0 && ph <= PH_SUM3) begin
      sum_rx_q    = {sum_rx_q[23:0], b};
      hdr_phase_q = (ph == PH_SUM3) ? after_sum : crcfr_phase_e'(ph + 4'd1);
    end else begin
      crc_q = crc32_step(crc_q, b);
      if (ph >= PH_SKIP0 && ph <= PH_SKIP3) begin
        hdr_phase_q = crcfr_phase_e'(ph + 4'd1);
      end else if (ph == PH_TYPE) begin
        type_q      = b;
        hdr_phase_q = PH_PAYLOAD;
      end else begin
        beats_due_q.push_back(make_item(KindPayload, b, last, type_q, ST_OK));
      end
    end
    if (last) begin
      type_seen = (hdr_phase_q == PH_PAYLOAD) || (ph >= PH_PAYLOAD);
      if (!type_seen) st = ST_SHORT;
      else if (sum_present_q && (~crc_q != sum_rx_q)) st = ST_MISMATCH;
      else st = ST_OK;
      beats_due_q.push_back(make_item(KindVerdict, 8'h00, 1'b0, type_q, st));
      clear_frame();
    end
  endtask

  task automatic check_beat();
    crcfr_item_t got;
    crcfr_item_t want;
    got.kind           = m_axis_tuser_i;
    got.payload_byte   = m_axis_tdata_i[7:0];
    got.end_of_payload = m_axis_tlast_i;
    got.frame_type     = m_axis_tdata_i[15:8];
    got.status         = crcfr_status_e'(m_axis_tdata_i[17:16]);
    if (beats_due_q.size() == 0) begin
      fails++;
      $display("%0t: unexpected output beat kind=%0b byte=%02h last=%0b type=%02h st=%0d",
               $time, got.kind, got.payload_byte, got.end_of_payload, got.frame_type,
               got.status);
      return;
    end
    want = beats_due_q.pop_front();
    if (got !== want || m_axis_tdata_i[23:18] !== 6'd0) begin
      fails++;
      $display("%0t: mismatch, expected %h pad 0, actual %h pad %h",
               $time, want, got, m_axis_tdata_i[23:18]);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_hdr_q = 1'b0;
      clear_frame();
      beats_due_q.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) skip_hdr_q = cfg_data_i;
      if (s_axis_tvalid_i && s_axis_tready_i) predict_byte(s_axis_tdata_i, s_axis_tlast_i);
      if (m_axis_tvalid_i && m_axis_tready_i) check_beat();
      fail_count_o <= fails;
      pending_o    <= beats_due_q.size();
    end
  end

endmodule

FILE: tb/tb_top.sv
// Testbench top for the CRC-checked frame receiver: clock, reset, frame stimulus,
// output back-pressure and the verdict. Depends on crcfr_pkg, the receiver RTL
// and crcfr_checker, which does all prediction and comparison.
`timescale 1ns / 1ps

module tb_top;
  import crcfr_pkg::*;

  localparam int unsigned RandomBytes  = 1500;
  localparam int unsigned QuietTail    = 300;
  localparam int unsigned SettleCycles = 10;
  localparam int unsigned HoldCycles   = 200;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;
  logic        s_valid;
  logic        s_ready;
  logic [7:0]  s_data;
  logic        s_last;
  logic        m_valid;
  logic        m_ready;
  logic [23:0] m_data;
  logic        m_last;
  logic        m_user;
  int unsigned fail_count;
  int unsigned pending;

  logic [7:0]  frame_q[$];
  int unsigned bytes_sent;
  bit          idle_on;
  bit          hold_req;
  bit          hold_done;
  logic        mode_now;

  crc_checked_frame_receiver_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last),
    .m_axis_tuser_o  (m_user)
  );

  crcfr_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_i (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_i (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_i  (m_data),
    .m_axis_tlast_i  (m_last),
    .m_axis_tuser_i  (m_user),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

  // Output side: random stall bursts, plus one long hold-off on request so the
  // result queue fills and the input side has to stall.
  initial begin
    m_ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
        m_ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        m_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
        m_ready <= 1'b1;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  task automatic put_byte(input logic [7:0] b, input logic last);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= b;
    s_last  <= last;
    do @(posedge clk_i); while (!s_ready);
    bytes_sent++;
  endtask

  // Sends count bytes of the built frame from index first; tlast goes on the final byte.
  task automatic send_span(input int unsigned first, input int unsigned count);
    for (int unsigned i = first; i < first + count; i++)
      put_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  // Waits until every predicted beat has come out, then lets the pipeline settle
  // since bytes of the header produce no beat of their own.
  task automatic drain();
    s_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mode_now = v;
  endtask

  // Builds mask, optional big-endian checksum, optional skip bytes, type and
  // payload into frame_q. A nonzero keep cuts the frame to that many bytes.
  task automatic build_frame(input logic [7:0] mask, input bit sum_good, input bit skip4,
                             input logic [7:0] ftype, input int unsigned plen,
                             input int unsigned keep);
    logic [7:0]  body[$];
    logic [31:0] crc;
    body = {};
    if (skip4) repeat (4) body.push_back(8'($urandom));
    body.push_back(ftype);
    repeat (plen) body.push_back(8'($urandom));
    crc = CrcInit;
    foreach (body[i]) crc = crc_byte(crc, body[i]);
    crc = ~crc;
    if (!sum_good) crc = crc ^ (32'd1 << $urandom_range(0, 31));
    frame_q = {mask};
    if (mask[MaskCrcBit])
      for (int i = 3; i >= 0; i--) frame_q.push_back(crc[8*i +: 8]);
    frame_q = {frame_q, body};
    if (keep != 0 && keep < frame_q.size()) frame_q = frame_q[0:keep-1];
  endtask

  // Mostly well-formed frames; some with a bad checksum, the wrong skip assumption or cut short.
  task automatic random_frame();
    logic [7:0]  mask;
    bit          good;
    bit          skip4;
    int unsigned plen;
    int unsigned keep;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    mask = 8'($urandom);
    mask[MaskCrcBit] = ($urandom_range(0, 9) < 7);
    good  = ($urandom_range(0, 3) != 0);
    skip4 = mode_now;
    plen  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
    keep  = 0;
    if (pick == 0) skip4 = !skip4;
    else if (pick == 1) keep = $urandom_range(1, 10);
    build_frame(mask, good, skip4, 8'($urandom), plen, keep);
    send_span(0, frame_q.size());
  endtask

  initial begin
    rst_ni    <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data  <= 1'b0;
    s_valid   <= 1'b0;
    s_data    <= 8'h00;
    s_last    <= 1'b0;
    idle_on   = 1'b1;
    hold_req  = 1'b0;
    hold_done = 1'b0;
    mode_now  = 1'b0;
    bytes_sent = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames in server mode: no checksum with the most negative type,
    // good checksum with empty payload and the largest type, bad checksum,
    // and a frame that ends on its mask byte.
    write_mode(1'b0);
    build_frame(8'h00, 1'b1, 1'b0, 8'h80, 1, 0);
    send_span(0, frame_q.size());
    build_frame(8'hFF, 1'b1, 1'b0, 8'h7F, 0, 0);
    send_span(0, frame_q.size());
    build_frame(8'h08, 1'b0, 1'b0, 8'h01, 0, 0);
    send_span(0, frame_q.size());
    build_frame(8'h00, 1'b1, 1'b0, 8'h00, 0, 1);
    send_span(0, frame_q.size());

    // Switch to client mode in the middle of the checksum field; the skip is
    // decided when the field ends, so the frame is built with the skip bytes.
    build_frame(8'h08, 1'b1, 1'b1, 8'hC3, 1, 0);
    send_span(0, 3);
    drain();
    write_mode(1'b1);
    send_span(3, frame_q.size() - 3);

    while (bytes_sent < RandomBytes) begin
      drain();
      write_mode(1'($urandom_range(0, 1)));
      if (bytes_sent + QuietTail > RandomBytes) idle_on = 1'b0;
      else idle_on = ($urandom_range(0, 3) != 0);
      if (!hold_done && bytes_sent > RandomBytes / 2) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      repeat ($urandom_range(3, 12)) random_frame();
    end
    drain();

    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
